// ===== hw/rtl/tscc_pkg.sv =====
// ----------------------------------------------------------------------------
// tscc_pkg
// Shared types, constants and helpers of the TS continuity counter checker.
// ----------------------------------------------------------------------------
package tscc_pkg;

   // Counter width of the per-PID and total counts
   localparam int CountWidth = 32;
   // Width of the count fields on the result port
   localparam int OutWidth   = 32;

   localparam int HdrWidth   = 32;
   localparam int PidWidth   = 13;
   localparam int CcWidth    = 4;
   localparam int AfcWidth   = 2;
   localparam int NumPids    = 1 << PidWidth;

   localparam logic [7:0]          SyncByte     = 8'h47;
   localparam logic [PidWidth-1:0] NullPid      = 13'h1FFF;
   localparam logic [AfcWidth-1:0] AfcAdaptOnly = 2'b10;
   localparam logic [AfcWidth-1:0] AfcReserved  = 2'b00;

   // One table entry per PID
   typedef struct packed {
      logic                  seen;
      logic [CcWidth-1:0]    last_cc;
      logic [CountWidth-1:0] pkts;
      logic [CountWidth-1:0] errs;
   } entry_type;

   localparam int EntryWidth = $bits(entry_type);

   // Result of one header
   typedef struct packed {
      logic [PidWidth-1:0] pid_value;
      logic                sync_error;
      logic                null_packet;
      logic                first_seen;
      logic                cc_error;
      logic [OutWidth-1:0] pid_packets;
      logic [OutWidth-1:0] pid_errors;
      logic [OutWidth-1:0] total_error_count;
   } result_type;

   // Saturating increment of a count
   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
      sat_inc = (v == {CountWidth{1'b1}}) ? v : v + CountWidth'(1);
   endfunction

endpackage

// ===== hw/rtl/tscc_ram.sv =====
// ----------------------------------------------------------------------------
// tscc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tscc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tscc_update.sv =====
// ----------------------------------------------------------------------------
// tscc_update
// Checks one header against its PID entry and builds the new entry,
// the new total and the result.
// ----------------------------------------------------------------------------
module tscc_update import tscc_pkg::*; (
   input  logic [HdrWidth-1:0]   hdr,
   input  entry_type             entry,
   input  logic [CountWidth-1:0] total,
   output entry_type             entry_new,
   output logic                  entry_wr,
   output logic [CountWidth-1:0] total_new,
   output result_type            result
);

   logic [PidWidth-1:0] pid;
   logic [AfcWidth-1:0] afc;
   logic [CcWidth-1:0]  cc;
   logic                sync_err;
   logic                null_pkt;
   logic                payload;
   logic                mismatch;

   assign pid      = hdr[8 +: PidWidth];
   assign afc      = hdr[4 +: AfcWidth];
   assign cc       = hdr[CcWidth-1:0];
   assign sync_err = hdr[HdrWidth-1 -: 8] != SyncByte;
   assign null_pkt = pid == NullPid;
   assign payload  = (afc != AfcAdaptOnly) && (afc != AfcReserved);
   assign mismatch = cc != (entry.last_cc + CcWidth'(1));

   // Decide the table update
   always_comb begin
      entry_new = entry;
      entry_wr  = 1'b0;
      total_new = total;
      result    = '0;
      result.pid_value = pid;
      priority if (sync_err) begin
         result.sync_error = 1'b1;
      end else if (null_pkt) begin
         result.null_packet = 1'b1;
      end else if (!entry.seen) begin
         entry_wr          = 1'b1;
         entry_new.seen    = 1'b1;
         entry_new.last_cc = cc;
         result.first_seen = 1'b1;
      end else begin
         entry_wr       = 1'b1;
         entry_new.pkts = sat_inc(entry.pkts);
         if (payload) begin
            entry_new.last_cc = cc;
            if (mismatch) begin
               result.cc_error = 1'b1;
               entry_new.errs  = sat_inc(entry.errs);
               total_new       = sat_inc(total);
            end
         end
      end
      if (!sync_err && !null_pkt) begin
         result.pid_packets = OutWidth'(entry_new.pkts);
         result.pid_errors  = OutWidth'(entry_new.errs);
      end
      result.total_error_count = OutWidth'(total_new);
   end

endmodule

// ===== hw/rtl/ts_continuity_counter_checker_top.sv =====
// ----------------------------------------------------------------------------
// ts_continuity_counter_checker_top
// Per-PID continuity counter check of MPEG transport stream headers.
// ----------------------------------------------------------------------------
//  channel | direction | payload                                   | flow
//  req     | in        | ts_header[32]                             | valid/stall
//  rsp     | out       | pid, flags, pid counts, total error count | valid/stall
//
//  One header per cycle while req_stall is low; each header passes the
//  table read and the update stage, then the update loads its result into
//  the output register, from which it leaves when rsp_stall is low.
//  The PID table lives in one RAM; the update writes back with forwarding
//  to a header that reads the same PID in the cycle of that write-back.
//  After reset a clearing pass writes all 8192 entries, one per cycle;
//  req_stall stays high throughout the pass.
//  rsp_stall holds the output register and stalls the input through the
//  update stage.
// ----------------------------------------------------------------------------
module ts_continuity_counter_checker_top import tscc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [HdrWidth-1:0] req_ts_header,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PidWidth-1:0] rsp_pid_value,
   output logic                rsp_sync_error,
   output logic                rsp_null_packet,
   output logic                rsp_first_seen,
   output logic                rsp_cc_error,
   output logic [OutWidth-1:0] rsp_pid_packets,
   output logic [OutWidth-1:0] rsp_pid_errors,
   output logic [OutWidth-1:0] rsp_total_error_count
);

   // Clearing pass
   logic                clear_ff, clear_in;
   logic [PidWidth-1:0] clear_cnt_ff, clear_cnt_in;

   // Update stage
   logic                  s1_valid_ff, s1_valid_in;
   logic [HdrWidth-1:0]   s1_hdr_ff, s1_hdr_in;
   logic                  fwd_ff, fwd_in;
   entry_type             fwd_data_ff, fwd_data_in;
   logic [CountWidth-1:0] total_ff, total_in;

   // Output register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  out_free;
   logic                  s1_go;
   logic [PidWidth-1:0]   req_pid;
   logic [PidWidth-1:0]   s1_pid;
   logic [EntryWidth-1:0] rd_raw;
   entry_type             rd_entry;
   entry_type             cur_entry;
   entry_type             upd_entry;
   logic                  upd_wr;
   logic [CountWidth-1:0] upd_total;
   result_type            upd_result;
   logic                  wr_en;
   logic [PidWidth-1:0]   wr_addr;
   entry_type             wr_data;

   assign req_pid  = req_ts_header[8 +: PidWidth];
   assign s1_pid   = s1_hdr_ff[8 +: PidWidth];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_go    = s1_valid_ff && out_free;
   assign req_stall = clear_ff || (s1_valid_ff && !out_free);
   assign accept   = req_valid && !req_stall;

   assign rd_entry  = entry_type'(rd_raw);
   assign cur_entry = fwd_ff ? fwd_data_ff : rd_entry;

   // Table RAM
   tscc_ram #(
      .Width (EntryWidth),
      .Depth (NumPids)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (req_pid),
      .rd_data (rd_raw)
   );

   // Check and update
   tscc_update u_update (
      .hdr       (s1_hdr_ff),
      .entry     (cur_entry),
      .total     (total_ff),
      .entry_new (upd_entry),
      .entry_wr  (upd_wr),
      .total_new (upd_total),
      .result    (upd_result)
   );

   // Select the write: clearing pass or write-back
   always_comb begin
      if (clear_ff) begin
         wr_en   = 1'b1;
         wr_addr = clear_cnt_ff;
         wr_data = '0;
      end else begin
         wr_en   = s1_go && upd_wr;
         wr_addr = s1_pid;
         wr_data = upd_entry;
      end
   end

   // Advance the clearing pass
   always_comb begin
      clear_cnt_in = clear_cnt_ff;
      clear_in     = clear_ff;
      if (clear_ff) begin
         clear_cnt_in = clear_cnt_ff + PidWidth'(1);
         if (clear_cnt_ff == {PidWidth{1'b1}}) begin
            clear_in = 1'b0;
         end
      end
   end

   // Move items through the update stage and the output register
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_hdr_in    = s1_hdr_ff;
      fwd_in       = fwd_ff;
      fwd_data_in  = fwd_data_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_go) begin
         s1_valid_in  = 1'b0;
         total_in     = upd_total;
         rsp_valid_in = 1'b1;
         rsp_data_in  = upd_result;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_hdr_in   = req_ts_header;
         // forward a write-back to the same PID that the RAM read misses
         fwd_in      = s1_go && upd_wr && (s1_pid == req_pid);
         fwd_data_in = upd_entry;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         clear_ff     <= clear_in;
         clear_cnt_ff <= clear_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_hdr_ff   <= s1_hdr_in;
      fwd_ff      <= fwd_in;
      fwd_data_ff <= fwd_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_pid_value         = rsp_data_ff.pid_value;
   assign rsp_sync_error        = rsp_data_ff.sync_error;
   assign rsp_null_packet       = rsp_data_ff.null_packet;
   assign rsp_first_seen        = rsp_data_ff.first_seen;
   assign rsp_cc_error          = rsp_data_ff.cc_error;
   assign rsp_pid_packets       = rsp_data_ff.pid_packets;
   assign rsp_pid_errors        = rsp_data_ff.pid_errors;
   assign rsp_total_error_count = rsp_data_ff.total_error_count;

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench of the TS continuity counter checker. Headers are sent through the
// req channel and every rsp transfer is compared field by field with a
// per-PID table model kept here. Directed headers cover bad sync bytes, the
// null PID, first headers, counter wrap, no-payload packets and counter
// errors. Random well-formed PID streams with occasional broken headers
// follow, first with random idling on both sides, then at full rate.
// ----------------------------------------------------------------------------
module tb import tscc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TimeoutCycles = 400000;
   localparam int DrainCycles   = 10;
   localparam int PoolSize      = 8;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [HdrWidth-1:0] req_ts_header = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [PidWidth-1:0] rsp_pid_value;
   logic                rsp_sync_error;
   logic                rsp_null_packet;
   logic                rsp_first_seen;
   logic                rsp_cc_error;
   logic [OutWidth-1:0] rsp_pid_packets;
   logic [OutWidth-1:0] rsp_pid_errors;
   logic [OutWidth-1:0] rsp_total_error_count;

   // Per-PID table model
   bit                  pid_seen [NumPids];
   bit [CcWidth-1:0]    pid_last_cc [NumPids];
   bit [CountWidth-1:0] pid_pkts [NumPids];
   bit [CountWidth-1:0] pid_errs [NumPids];
   bit [CountWidth-1:0] total_cc_errors = '0;

   result_type          pending_results [$];
   int unsigned         mismatch_count = 0;
   int unsigned         cycle_count = 0;
   bit                  idle_on = 1'b1;
   int unsigned         stall_left = 0;

   // Stream generator state
   logic [PidWidth-1:0] stream_pids [PoolSize];
   int                  last_slot = 0;

   ts_continuity_counter_checker_top u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_ts_header         (req_ts_header),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_pid_value         (rsp_pid_value),
      .rsp_sync_error        (rsp_sync_error),
      .rsp_null_packet       (rsp_null_packet),
      .rsp_first_seen        (rsp_first_seen),
      .rsp_cc_error          (rsp_cc_error),
      .rsp_pid_packets       (rsp_pid_packets),
      .rsp_pid_errors        (rsp_pid_errors),
      .rsp_total_error_count (rsp_total_error_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Saturating count step
   function automatic bit [CountWidth-1:0] bump_count(input bit [CountWidth-1:0] v);
      bump_count = (v == {CountWidth{1'b1}}) ? v : v + 1'b1;
   endfunction

   // Update the table model with one accepted header and queue its result
   task automatic predict_continuity(input logic [HdrWidth-1:0] hdr);
      result_type          r;
      logic [PidWidth-1:0] pid;
      logic [AfcWidth-1:0] afc;
      logic [CcWidth-1:0]  cc;
      pid = hdr[20:8];
      afc = hdr[5:4];
      cc  = hdr[3:0];
      r = '0;
      r.pid_value = pid;
      if (hdr[31:24] != SyncByte) begin
         r.sync_error = 1'b1;
      end else if (pid == NullPid) begin
         r.null_packet = 1'b1;
      end else if (!pid_seen[pid]) begin
         pid_seen[pid]    = 1'b1;
         pid_last_cc[pid] = cc;
         r.first_seen     = 1'b1;
         r.pid_packets    = pid_pkts[pid];
         r.pid_errors     = pid_errs[pid];
      end else begin
         pid_pkts[pid] = bump_count(pid_pkts[pid]);
         // check only packets that carry a payload
         if (afc != AfcAdaptOnly && afc != AfcReserved) begin
            if (cc != CcWidth'(pid_last_cc[pid] + 1'b1)) begin
               r.cc_error      = 1'b1;
               pid_errs[pid]   = bump_count(pid_errs[pid]);
               total_cc_errors = bump_count(total_cc_errors);
            end
            pid_last_cc[pid] = cc;
         end
         r.pid_packets = pid_pkts[pid];
         r.pid_errors  = pid_errs[pid];
      end
      r.total_error_count = total_cc_errors;
      pending_results.insert(pending_results.size(), r);
   endtask

   // Send one header, with an optional idle burst ahead of it
   task automatic send_header(input logic [HdrWidth-1:0] hdr);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_ts_header <= hdr;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_continuity(hdr);
   endtask

   // Build a header; flag bits and scrambling control are random
   function automatic logic [HdrWidth-1:0] make_header(input logic [7:0] sync,
         input logic [PidWidth-1:0] pid, input logic [AfcWidth-1:0] afc,
         input logic [CcWidth-1:0] cc);
      make_header = {sync, 3'($urandom), pid, 2'($urandom), afc, cc};
   endfunction

   function automatic logic [PidWidth-1:0] random_pid();
      logic [PidWidth-1:0] pid;
      pid = PidWidth'($urandom);
      random_pid = (pid == NullPid) ? pid - 1'b1 : pid;
   endfunction

   task automatic compare_field(input string name, input logic [OutWidth-1:0] want,
         input logic [OutWidth-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Check each rsp transfer and drive rsp_stall in random bursts
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("result with none expected, pid 0x%0h", rsp_pid_value);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("pid_value", OutWidth'(want.pid_value),
                          OutWidth'(rsp_pid_value));
            compare_field("sync_error", OutWidth'(want.sync_error),
                          OutWidth'(rsp_sync_error));
            compare_field("null_packet", OutWidth'(want.null_packet),
                          OutWidth'(rsp_null_packet));
            compare_field("first_seen", OutWidth'(want.first_seen),
                          OutWidth'(rsp_first_seen));
            compare_field("cc_error", OutWidth'(want.cc_error),
                          OutWidth'(rsp_cc_error));
            compare_field("pid_packets", want.pid_packets, rsp_pid_packets);
            compare_field("pid_errors", want.pid_errors, rsp_pid_errors);
            compare_field("total_error_count", want.total_error_count,
                          rsp_total_error_count);
         end
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Headers whose top byte is not the sync byte
   task automatic test_sync_byte();
      send_header(32'h0000_0000);
      send_header(32'hFFFF_FFFF);
      send_header(make_header(8'h46, 13'h0123, 2'b01, 4'h0));
      send_header(make_header(8'h48, 13'h1FFF, 2'b11, 4'hF));
      send_header(make_header(8'hC7, 13'h0000, 2'b01, 4'h5));
   endtask

   // Null PID headers leave the table alone
   task automatic test_null_pid();
      send_header(32'h47FF_FFFF);
      send_header(make_header(SyncByte, NullPid, 2'b01, 4'h0));
      send_header(make_header(SyncByte, NullPid, AfcReserved, 4'h9));
   endtask

   // First header of a PID records its counter
   task automatic test_first_header();
      send_header(make_header(SyncByte, 13'h0000, 2'b01, 4'hF));
      send_header(make_header(SyncByte, 13'h1FFE, 2'b11, 4'h0));
      send_header(make_header(SyncByte, 13'h0AAA, AfcReserved, 4'h7));
   endtask

   // Counter sequence: wrap, no-payload packets, errors and resync
   task automatic test_continuity();
      send_header(make_header(SyncByte, 13'h0000, 2'b01, 4'h0));
      send_header(make_header(SyncByte, 13'h0000, 2'b11, 4'h1));
      send_header(make_header(SyncByte, 13'h0000, AfcAdaptOnly, 4'h1));
      send_header(make_header(SyncByte, 13'h0000, AfcReserved, 4'h5));
      send_header(make_header(SyncByte, 13'h0000, 2'b01, 4'h2));
      send_header(make_header(SyncByte, 13'h0000, 2'b01, 4'h9));
      send_header(make_header(SyncByte, 13'h0000, 2'b11, 4'hA));
      send_header(make_header(SyncByte, 13'h0000, 2'b01, 4'hA));
      send_header(make_header(SyncByte, 13'h1FFE, 2'b01, 4'h1));
      send_header(make_header(SyncByte, 13'h1FFE, 2'b11, 4'h3));
   endtask

   // One random item: mostly in-order PID streams, some broken headers
   task automatic send_stream_item();
      int                  pick;
      int                  slot;
      logic [7:0]          sync;
      logic [PidWidth-1:0] pid;
      logic [AfcWidth-1:0] afc;
      logic [CcWidth-1:0]  cc;
      pick = $urandom_range(0, 99);
      slot = ($urandom_range(0, 1) == 0) ? last_slot : $urandom_range(0, PoolSize - 1);
      last_slot = slot;
      // bring in a fresh PID now and then
      if ($urandom_range(0, 29) == 0) stream_pids[slot] = random_pid();
      pid = stream_pids[slot];
      if (pick < 4) begin
         send_header(HdrWidth'($urandom));
      end else if (pick < 9) begin
         sync = 8'($urandom);
         if (sync == SyncByte) sync = ~sync;
         send_header(make_header(sync, pid, 2'($urandom), 4'($urandom)));
      end else if (pick < 12) begin
         send_header(make_header(SyncByte, NullPid, 2'($urandom), 4'($urandom)));
      end else begin
         afc = ($urandom_range(0, 4) == 0) ? 2'($urandom) : {1'($urandom), 1'b1};
         if (pid_seen[pid] && $urandom_range(0, 9) != 0)
            cc = pid_last_cc[pid] + 1'b1;
         else
            cc = 4'($urandom);
         send_header(make_header(SyncByte, pid, afc, cc));
      end
   endtask

   task automatic test_random_streams(input int count);
      for (int i = 0; i < PoolSize; i++) stream_pids[i] = random_pid();
      repeat (count) send_stream_item();
   endtask

   // Full rate with no idling on either side
   task automatic test_line_rate(input int count);
      idle_on = 1'b0;
      repeat (count) send_stream_item();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_sync_byte();
      test_null_pid();
      test_first_header();
      test_continuity();
      test_random_streams(1200);
      test_line_rate(200);
      req_valid <= 1'b0;
      // drain the pipeline
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ts_continuity_counter_checker_top: match");
      end else begin
         $display("ts_continuity_counter_checker_top: mismatch");
      end
      $finish;
   end

   // Timeout
   initial begin
      while (cycle_count < TimeoutCycles) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ts_continuity_counter_checker_top: mismatch");
      $finish;
   end

endmodule
